// ----- sv/chacha_stream_cipher_unit_defines.svh -----
// assertion macros shared by the checker of the chacha stream cipher unit
`ifndef CHACHA_STREAM_CIPHER_UNIT_DEFINES_SVH
`define CHACHA_STREAM_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/csu_pkg.sv -----
// shared types, constants and helper functions of the chacha stream cipher unit
`default_nettype none

package csu_pkg;

  typedef logic [31:0] csu_word_t;
  typedef logic [15:0][31:0] csu_block_t;

  localparam csu_word_t SIGMA0 = 32'h61707865;
  localparam csu_word_t SIGMA1 = 32'h3320646e;
  localparam csu_word_t SIGMA2 = 32'h79622d32;
  localparam csu_word_t SIGMA3 = 32'h6b206574;

  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  localparam logic [4:0] ROUNDS_RESET = 5'd20;

  typedef enum logic [2:0] {
    REG_KEY0,
    REG_KEY1,
    REG_KEY2,
    REG_KEY3,
    REG_IV_LOW,
    REG_IV_HIGH,
    REG_ROUNDS
  } csu_reg_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      iv_low;
    logic [63:0]      iv_high;
    logic [4:0]       rounds;
  } csu_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } csu_state_t;

  function automatic csu_word_t rotl(csu_word_t v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // initial cipher state from configuration and block counter
  function automatic csu_block_t init_state(csu_cfg_t cfg, csu_word_t ctr);
    csu_block_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[4]  = cfg.key[0][31:0];
    s[5]  = cfg.key[0][63:32];
    s[6]  = cfg.key[1][31:0];
    s[7]  = cfg.key[1][63:32];
    s[8]  = cfg.key[2][31:0];
    s[9]  = cfg.key[2][63:32];
    s[10] = cfg.key[3][31:0];
    s[11] = cfg.key[3][63:32];
    s[12] = ctr;
    s[13] = cfg.iv_low[63:32];
    s[14] = cfg.iv_high[31:0];
    s[15] = cfg.iv_high[63:32];
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- sv/csu_quarter.sv -----
// one chacha quarter-round lane
`default_nettype none

module csu_quarter (
  input  wire csu_pkg::csu_word_t a_i,
  input  wire csu_pkg::csu_word_t b_i,
  input  wire csu_pkg::csu_word_t c_i,
  input  wire csu_pkg::csu_word_t d_i,
  output csu_pkg::csu_word_t      a_o,
  output csu_pkg::csu_word_t      b_o,
  output csu_pkg::csu_word_t      c_o,
  output csu_pkg::csu_word_t      d_o
);

  csu_pkg::csu_word_t a1, b1, c1, d1;

  always_comb begin
    a1  = a_i + b_i;
    d1  = csu_pkg::rotl(d_i ^ a1, csu_pkg::ROT_A);
    c1  = c_i + d1;
    b1  = csu_pkg::rotl(b_i ^ c1, csu_pkg::ROT_B);
    a_o = a1 + b1;
    d_o = csu_pkg::rotl(d1 ^ a_o, csu_pkg::ROT_C);
    c_o = c1 + d_o;
    b_o = csu_pkg::rotl(b1 ^ c_o, csu_pkg::ROT_D);
  end

endmodule

`default_nettype wire

// ----- sv/csu_round.sv -----
// shared round unit: four quarter-round lanes routed as a column or a diagonal round
`default_nettype none

module csu_round (
  input  wire csu_pkg::csu_block_t blk_i,
  input  wire logic                diag_i,
  output csu_pkg::csu_block_t      blk_o
);

  csu_pkg::csu_word_t la [4];
  csu_pkg::csu_word_t lb [4];
  csu_pkg::csu_word_t lc [4];
  csu_pkg::csu_word_t ld [4];
  csu_pkg::csu_word_t qa [4];
  csu_pkg::csu_word_t qb [4];
  csu_pkg::csu_word_t qc [4];
  csu_pkg::csu_word_t qd [4];

  // lane j works on a=j, b=4+((j+k)&3), c=8+((j+2k)&3), d=12+((j+3k)&3), k=1 on a diagonal round
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      la[j] = blk_i[j];
      if (diag_i) begin
        lb[j] = blk_i[4 + ((j + 1) & 3)];
        lc[j] = blk_i[8 + ((j + 2) & 3)];
        ld[j] = blk_i[12 + ((j + 3) & 3)];
      end else begin
        lb[j] = blk_i[4 + j];
        lc[j] = blk_i[8 + j];
        ld[j] = blk_i[12 + j];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    csu_quarter u_quarter (
      .a_i (la[g]),
      .b_i (lb[g]),
      .c_i (lc[g]),
      .d_i (ld[g]),
      .a_o (qa[g]),
      .b_o (qb[g]),
      .c_o (qc[g]),
      .d_o (qd[g])
    );
  end

  always_comb begin
    blk_o = blk_i;
    for (int j = 0; j < 4; j++) begin
      blk_o[j] = qa[j];
      if (diag_i) begin
        blk_o[4 + ((j + 1) & 3)]  = qb[j];
        blk_o[8 + ((j + 2) & 3)]  = qc[j];
        blk_o[12 + ((j + 3) & 3)] = qd[j];
      end else begin
        blk_o[4 + j]  = qb[j];
        blk_o[8 + j]  = qc[j];
        blk_o[12 + j] = qd[j];
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/csu_regs.sv -----
// apb-style configuration registers: key, counter/nonce and round count
`default_nettype none

module csu_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output csu_pkg::csu_cfg_t cfg_o
);

  logic [3:0][63:0] key_r, key_nxt;
  logic [63:0]      iv_low_r, iv_low_nxt;
  logic [63:0]      iv_high_r, iv_high_nxt;
  logic [4:0]       rounds_r, rounds_nxt;
  csu_pkg::csu_reg_t idx;
  logic             wr_en;

  // registers sit on 8-byte boundaries
  assign idx    = csu_pkg::csu_reg_t'(paddr[5:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    key_nxt     = key_r;
    iv_low_nxt  = iv_low_r;
    iv_high_nxt = iv_high_r;
    rounds_nxt  = rounds_r;
    prdata      = '0;
    case (idx)
      csu_pkg::REG_KEY0: begin
        prdata = key_r[0];
        if (wr_en) key_nxt[0] = pwdata;
      end
      csu_pkg::REG_KEY1: begin
        prdata = key_r[1];
        if (wr_en) key_nxt[1] = pwdata;
      end
      csu_pkg::REG_KEY2: begin
        prdata = key_r[2];
        if (wr_en) key_nxt[2] = pwdata;
      end
      csu_pkg::REG_KEY3: begin
        prdata = key_r[3];
        if (wr_en) key_nxt[3] = pwdata;
      end
      csu_pkg::REG_IV_LOW: begin
        prdata = iv_low_r;
        if (wr_en) iv_low_nxt = pwdata;
      end
      csu_pkg::REG_IV_HIGH: begin
        prdata = iv_high_r;
        if (wr_en) iv_high_nxt = pwdata;
      end
      csu_pkg::REG_ROUNDS: begin
        prdata = {59'd0, rounds_r};
        if (wr_en) rounds_nxt = pwdata[4:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      iv_low_r  <= '0;
      iv_high_r <= '0;
      rounds_r  <= csu_pkg::ROUNDS_RESET;
    end else begin
      key_r     <= key_nxt;
      iv_low_r  <= iv_low_nxt;
      iv_high_r <= iv_high_nxt;
      rounds_r  <= rounds_nxt;
    end
  end

  always_comb begin
    cfg_o.key     = key_r;
    cfg_o.iv_low  = iv_low_r;
    cfg_o.iv_high = iv_high_r;
    cfg_o.rounds  = rounds_r;
  end

endmodule

`default_nettype wire

// ----- sv/csu_core.sv -----
// sequencer, working state, block counter and output register of the cipher
`default_nettype none

module csu_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire csu_pkg::csu_cfg_t cfg_i,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [63:0]       in_data_in,
  input  wire logic [3:0]        in_bytes_valid,
  input  wire logic              in_last_of_call,
  input  wire logic              in_restart,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [63:0]            out_data_out,
  output logic [3:0]             out_bytes_out,
  output logic                   out_last_out
);

  csu_pkg::csu_state_t state_r, state_nxt;
  csu_pkg::csu_block_t w_r, w_nxt;
  csu_pkg::csu_block_t round_out;
  csu_pkg::csu_block_t fin_init;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [5:0]  rounds_total;
  logic [31:0] ctr_r, ctr_nxt;
  logic [31:0] ctr_use;
  logic [2:0]  pos_r, pos_nxt;
  logic        blk_ready_r, blk_ready_nxt;
  logic [63:0] data_r, data_nxt;
  logic [3:0]  nbytes_r, nbytes_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [3:0]  out_bytes_r, out_bytes_nxt;
  logic        out_last_r, out_last_nxt;
  logic [63:0] ks_word;
  logic [63:0] mask;

  csu_round u_round (
    .blk_i  (w_r),
    .diag_i (rnd_r[0]),
    .blk_o  (round_out)
  );

  // an odd round count rounds up to the next even count
  assign rounds_total = {1'b0, cfg_i.rounds} + {5'd0, cfg_i.rounds[0]};
  assign ctr_use      = in_restart ? cfg_i.iv_low[31:0] : ctr_r;
  assign fin_init     = csu_pkg::init_state(cfg_i, ctr_r);
  assign ks_word      = {w_r[{pos_r, 1'b1}], w_r[{pos_r, 1'b0}]};

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask[8*k +: 8] = (nbytes_r > 4'(k)) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    rnd_nxt       = rnd_r;
    ctr_nxt       = ctr_r;
    pos_nxt       = pos_r;
    blk_ready_nxt = blk_ready_r;
    data_nxt      = data_r;
    nbytes_nxt    = nbytes_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    in_ready      = (state_r == csu_pkg::ST_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      csu_pkg::ST_IDLE: begin
        if (in_valid) begin
          data_nxt   = in_data_in;
          nbytes_nxt = in_bytes_valid;
          last_nxt   = in_last_of_call;
          if (in_restart || !blk_ready_r) begin
            ctr_nxt   = ctr_use;
            w_nxt     = csu_pkg::init_state(cfg_i, ctr_use);
            rnd_nxt   = '0;
            state_nxt = (rounds_total == 6'd0) ? csu_pkg::ST_FINAL : csu_pkg::ST_ROUND;
          end else begin
            state_nxt = csu_pkg::ST_EMIT;
          end
        end
      end
      csu_pkg::ST_ROUND: begin
        w_nxt   = round_out;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r + 6'd1 == rounds_total) begin
          state_nxt = csu_pkg::ST_FINAL;
        end
      end
      csu_pkg::ST_FINAL: begin
        // feed-forward of the initial state, then advance the counter
        for (int i = 0; i < 16; i++) begin
          w_nxt[i] = w_r[i] + fin_init[i];
        end
        ctr_nxt       = ctr_r + 32'd1;
        blk_ready_nxt = 1'b1;
        pos_nxt       = '0;
        state_nxt     = csu_pkg::ST_EMIT;
      end
      csu_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (data_r ^ ks_word) & mask;
          out_bytes_nxt = nbytes_r;
          out_last_nxt  = last_r;
          if (last_r) begin
            blk_ready_nxt = 1'b0;
            pos_nxt       = '0;
          end else begin
            pos_nxt = pos_r + 3'd1;
            if (pos_r == 3'd7) begin
              blk_ready_nxt = 1'b0;
            end
          end
          state_nxt = csu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csu_pkg::ST_IDLE;
      rnd_r       <= '0;
      ctr_r       <= '0;
      pos_r       <= '0;
      blk_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      ctr_r       <= ctr_nxt;
      pos_r       <= pos_nxt;
      blk_ready_r <= blk_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    data_r      <= data_nxt;
    nbytes_r    <= nbytes_nxt;
    last_r      <= last_nxt;
    out_data_r  <= out_data_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data_out  = out_data_r;
  assign out_bytes_out = out_bytes_r;
  assign out_last_out  = out_last_r;

endmodule

`default_nettype wire

// ----- sv/chacha_stream_cipher_unit.sv -----
// ChaCha stream cipher unit: XORs 64-bit little-endian words with the keystream, one
// request at a time. A word that needs a fresh 64-byte block (first word of a call,
// the first word of every further group of eight, or a request with restart set) runs
// the rounds (round_count, rounded up to even) and a feed-forward step before its result
// enters the output register; every other word takes its keystream from the held block.
// in_ready rises again as the result enters the output register; a stalled output holds
// the unit in its emit state until out_ready. The block time is set by the single round
// unit, whose four quarter-round lanes run one column or diagonal round per cycle.
// in_ready is low while a request is in flight, but a finished result may sit in the
// output register while the next request is accepted. The user must write the
// configuration registers only while the unit is idle; the block itself does not
// enforce this. No clearing pass follows reset.
`default_nettype none

module chacha_stream_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_data_in,
  input  wire logic [3:0]  in_bytes_valid,
  input  wire logic        in_last_of_call,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_data_out,
  output logic [3:0]       out_bytes_out,
  output logic             out_last_out
);

  csu_pkg::csu_cfg_t cfg;

  csu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csu_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_in      (in_data_in),
    .in_bytes_valid  (in_bytes_valid),
    .in_last_of_call (in_last_of_call),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_out    (out_data_out),
    .out_bytes_out   (out_bytes_out),
    .out_last_out    (out_last_out)
  );

endmodule

`default_nettype wire

// ----- sv/csu_checker.sv -----
// port-level checker of the chacha stream cipher unit, bound to the top level
`default_nettype none
`include "chacha_stream_cipher_unit_defines.svh"

module csu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        psel,
  input wire logic        pready,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_data_out,
  input wire logic [3:0]  out_bytes_out
);

  // an accepted request takes in_ready low
  `CSU_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after request")

  // a single valid byte leaves the upper seven bytes zero
  `CSU_ASSERT_NOW(a_one_byte_mask, out_valid && out_bytes_out == 4'd1,
                  out_data_out[63:8] == 56'd0, "bytes beyond count not zero")

  // a held result keeps its data
  `CSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_data_out), "stalled result changed")

  // the configuration port never stalls
  `CSU_ASSERT_NOW(a_cfg_no_wait, psel, pready, "configuration port stalled")

endmodule

bind chacha_stream_cipher_unit csu_checker u_csu_checker (.*);

`default_nettype wire
